FILE: hw/rtl/nwt_pkg.sv
// Shared types, constants and command/status structs for the number-to-word token block.
`default_nettype none

package nwt_pkg;

	localparam int VALUE_W       = 40;
	localparam int DIGITS        = 13;
	localparam int BCD_W         = DIGITS * 4;
	localparam int BITS_PER_STEP = 4;
	localparam int NSTEP         = VALUE_W / BITS_PER_STEP;
	localparam int CNT_W         = $clog2(NSTEP + 1);
	localparam int KIND_W        = 3;
	localparam int INDEX_W       = 5;

	localparam logic [INDEX_W-1:0] TEEN_BASE = INDEX_W'(10);
	localparam logic [INDEX_W-1:0] TENS_BASE = INDEX_W'(18);

	typedef logic [3:0] digit_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NUM      = 3'd0,
		KIND_AND      = 3'd1,
		KIND_HUNDRED  = 3'd2,
		KIND_THOUSAND = 3'd3,
		KIND_MILLION  = 3'd4,
		KIND_BILLION  = 3'd5
	} kind_t;

	// Digit groups in spoken order; GRP_BT is the thousands digit of the billions count.
	typedef enum logic [2:0] {
		GRP_BT,
		GRP_B,
		GRP_M,
		GRP_T,
		GRP_U
	} grp_t;

	typedef enum logic [1:0] {
		IDX_HUN,
		IDX_TENS,
		IDX_UNIT
	} idx_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_LEAD,
		ST_HWORD,
		ST_TENS,
		ST_UNIT,
		ST_SCALE,
		ST_AND
	} state_t;

	typedef struct packed {
		logic     load;
		logic     conv_step;
		logic     tok_load;
		kind_t    kind;
		idx_sel_t idx_sel;
		grp_t     grp;
		logic     last;
	} nwt_cmd_t;

	typedef struct packed {
		logic out_free;
		logic h_nz;
		logic t_ge2;
		logic tu_zero;
		logic u_zero;
		logic rest_zero;
		logic rest_lt100;
		logic b_top;
		logic b_low_nz;
		logic m_nz;
		logic th_nz;
	} nwt_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nwt_ifs.sv
// Valid/ready channel interfaces for number words in and tokens out.
`default_nettype none

interface nwt_num_if;
	logic                        valid;
	logic                        ready;
	logic [nwt_pkg::VALUE_W-1:0] value;
	logic                        ordinal;

	modport source(output valid, output value, output ordinal, input ready);
	modport sink(input valid, input value, input ordinal, output ready);
endinterface

interface nwt_tok_if;
	logic                        valid;
	logic                        ready;
	logic [nwt_pkg::KIND_W-1:0]  word_kind;
	logic [nwt_pkg::INDEX_W-1:0] word_index;
	logic                        ordinal_form;
	logic                        last_word;

	modport source(output valid, output word_kind, output word_index,
		output ordinal_form, output last_word, input ready);
	modport sink(input valid, input word_kind, input word_index,
		input ordinal_form, input last_word, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/nwt_dp.sv
// Datapath: binary to BCD conversion, digit group selection and token output register.
`default_nettype none

module nwt_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [nwt_pkg::VALUE_W-1:0] value,
	input  logic                        ordinal,
	input  nwt_pkg::nwt_cmd_t           cmd,
	output nwt_pkg::nwt_sts_t           sts,
	output logic                        tok_valid,
	input  logic                        tok_ready,
	output logic [nwt_pkg::KIND_W-1:0]  word_kind,
	output logic [nwt_pkg::INDEX_W-1:0] word_index,
	output logic                        ordinal_form,
	output logic                        last_word
);

	logic [nwt_pkg::VALUE_W-1:0] bin_q;
	logic [nwt_pkg::BCD_W-1:0]   bcd_q;
	logic                        ord_q;
	logic [nwt_pkg::VALUE_W-1:0] bin_n;
	logic [nwt_pkg::BCD_W-1:0]   bcd_n;

	logic                        out_valid_q;
	nwt_pkg::kind_t              kind_q;
	logic [nwt_pkg::INDEX_W-1:0] index_q;
	logic                        ordf_q;
	logic                        last_q;

	nwt_pkg::digit_t d [nwt_pkg::DIGITS];
	nwt_pkg::digit_t gh, gt, gu;
	logic g0_nz, g1_nz, hmode;
	logic [nwt_pkg::INDEX_W-1:0] idx;

	// Double dabble, several bits per cycle.
	always_comb begin
		bcd_n = bcd_q;
		bin_n = bin_q;
		for (int s = 0; s < nwt_pkg::BITS_PER_STEP; s++) begin
			for (int i = 0; i < nwt_pkg::DIGITS; i++) begin
				if (bcd_n[4*i +: 4] >= 4'd5) begin
					bcd_n[4*i +: 4] = bcd_n[4*i +: 4] + 4'd3;
				end
			end
			bcd_n = {bcd_n[nwt_pkg::BCD_W-2:0], bin_n[nwt_pkg::VALUE_W-1]};
			bin_n = {bin_n[nwt_pkg::VALUE_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= value;
			bcd_q <= '0;
			ord_q <= ordinal;
		end else if (cmd.conv_step) begin
			bin_q <= bin_n;
			bcd_q <= bcd_n;
		end
	end

	always_comb begin
		for (int i = 0; i < nwt_pkg::DIGITS; i++) begin
			d[i] = bcd_q[4*i +: 4];
		end
	end

	assign g0_nz = |{d[2], d[1], d[0]};
	assign g1_nz = |{d[5], d[4], d[3]};
	// 1100..1999 in the low six digits: read in hundreds
	assign hmode = (d[5] == 4'd0) && (d[4] == 4'd0) && (d[3] == 4'd1) && (d[2] != 4'd0);

	always_comb begin
		case (cmd.grp)
			nwt_pkg::GRP_BT: begin
				gh = '0;   gt = '0;    gu = d[12];
			end
			nwt_pkg::GRP_B: begin
				gh = d[11]; gt = d[10]; gu = d[9];
			end
			nwt_pkg::GRP_M: begin
				gh = d[8];  gt = d[7];  gu = d[6];
			end
			nwt_pkg::GRP_T: begin
				gh = d[5];  gt = d[4];  gu = d[3];
			end
			default: begin
				gh = d[2];  gt = d[1];  gu = d[0];
			end
		endcase
	end

	always_comb begin
		sts          = '0;
		sts.out_free = !out_valid_q || tok_ready;
		sts.h_nz     = gh != 4'd0;
		sts.t_ge2    = gt >= 4'd2;
		sts.tu_zero  = (gt == 4'd0) && (gu == 4'd0);
		sts.u_zero   = gu == 4'd0;
		sts.b_top    = d[12] != 4'd0;
		sts.b_low_nz = |{d[11], d[10], d[9]};
		sts.m_nz     = |{d[8], d[7], d[6]};
		sts.th_nz    = g1_nz && !hmode;
		case (cmd.grp)
			nwt_pkg::GRP_BT: begin
				sts.rest_zero  = !sts.b_low_nz;
				sts.rest_lt100 = d[11] == 4'd0;
			end
			nwt_pkg::GRP_B: begin
				sts.rest_zero  = !(sts.m_nz || g1_nz || g0_nz);
				sts.rest_lt100 = !(sts.m_nz || g1_nz || (d[2] != 4'd0));
			end
			nwt_pkg::GRP_M: begin
				sts.rest_zero  = !(g1_nz || g0_nz);
				sts.rest_lt100 = !(g1_nz || (d[2] != 4'd0));
			end
			nwt_pkg::GRP_T: begin
				sts.rest_zero  = !g0_nz;
				sts.rest_lt100 = d[2] == 4'd0;
			end
			default: begin
				sts.rest_zero  = 1'b1;
				sts.rest_lt100 = 1'b1;
			end
		endcase
	end

	always_comb begin
		case (cmd.idx_sel)
			nwt_pkg::IDX_HUN: begin
				idx = ((cmd.grp == nwt_pkg::GRP_U) && hmode) ?
					nwt_pkg::TEEN_BASE + {1'b0, gh} : {1'b0, gh};
			end
			nwt_pkg::IDX_TENS: begin
				idx = nwt_pkg::TENS_BASE + {1'b0, gt};
			end
			nwt_pkg::IDX_UNIT: begin
				idx = (gt == 4'd1) ? nwt_pkg::TEEN_BASE + {1'b0, gu} : {1'b0, gu};
			end
			default: begin
				idx = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.tok_load) begin
			out_valid_q <= 1'b1;
		end else if (tok_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tok_load) begin
			kind_q  <= cmd.kind;
			index_q <= (cmd.kind == nwt_pkg::KIND_NUM) ? idx : '0;
			ordf_q  <= cmd.last && ord_q;
			last_q  <= cmd.last;
		end
	end

	assign tok_valid    = out_valid_q;
	assign word_kind    = kind_q;
	assign word_index   = index_q;
	assign ordinal_form = ordf_q;
	assign last_word    = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/nwt_ctrl.sv
// Controller: sequences conversion and digit groups, one token per cycle unless stalled.
`default_nettype none

module nwt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  nwt_pkg::nwt_sts_t sts,
	output nwt_pkg::nwt_cmd_t cmd
);

	nwt_pkg::state_t           state_q, state_d;
	nwt_pkg::grp_t             grp_q, grp_d;
	logic [nwt_pkg::CNT_W-1:0] cnt_q, cnt_d;
	nwt_pkg::grp_t             first_grp, next_grp;
	nwt_pkg::state_t           grp_end_st;
	logic                      conv_done;

	assign conv_done  = cnt_q == nwt_pkg::CNT_W'(nwt_pkg::NSTEP);
	assign grp_end_st = (grp_q == nwt_pkg::GRP_U) ? nwt_pkg::ST_IDLE : nwt_pkg::ST_SCALE;

	always_comb begin
		if (sts.b_top) begin
			first_grp = nwt_pkg::GRP_BT;
		end else if (sts.b_low_nz) begin
			first_grp = nwt_pkg::GRP_B;
		end else if (sts.m_nz) begin
			first_grp = nwt_pkg::GRP_M;
		end else if (sts.th_nz) begin
			first_grp = nwt_pkg::GRP_T;
		end else begin
			first_grp = nwt_pkg::GRP_U;
		end
	end

	always_comb begin
		case (grp_q)
			nwt_pkg::GRP_BT: next_grp = nwt_pkg::GRP_B;
			nwt_pkg::GRP_B: begin
				if (sts.m_nz) begin
					next_grp = nwt_pkg::GRP_M;
				end else if (sts.th_nz) begin
					next_grp = nwt_pkg::GRP_T;
				end else begin
					next_grp = nwt_pkg::GRP_U;
				end
			end
			nwt_pkg::GRP_M: next_grp = sts.th_nz ? nwt_pkg::GRP_T : nwt_pkg::GRP_U;
			default: next_grp = nwt_pkg::GRP_U;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		grp_d   = grp_q;
		cnt_d   = cnt_q;
		case (state_q)
			nwt_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = nwt_pkg::ST_CONV;
					cnt_d   = '0;
				end
			end
			nwt_pkg::ST_CONV: begin
				if (conv_done) begin
					state_d = nwt_pkg::ST_LEAD;
					grp_d   = first_grp;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			nwt_pkg::ST_LEAD: begin
				if (sts.out_free) begin
					if (sts.h_nz) begin
						state_d = nwt_pkg::ST_HWORD;
					end else if (sts.t_ge2) begin
						state_d = sts.u_zero ? grp_end_st : nwt_pkg::ST_UNIT;
					end else begin
						state_d = grp_end_st;
					end
				end
			end
			nwt_pkg::ST_HWORD: begin
				if (sts.out_free) begin
					if (sts.tu_zero) begin
						state_d = grp_end_st;
					end else if (sts.t_ge2) begin
						state_d = nwt_pkg::ST_TENS;
					end else begin
						state_d = nwt_pkg::ST_UNIT;
					end
				end
			end
			nwt_pkg::ST_TENS: begin
				if (sts.out_free) begin
					state_d = sts.u_zero ? grp_end_st : nwt_pkg::ST_UNIT;
				end
			end
			nwt_pkg::ST_UNIT: begin
				if (sts.out_free) begin
					state_d = grp_end_st;
				end
			end
			nwt_pkg::ST_SCALE: begin
				if (sts.out_free) begin
					if (sts.rest_zero) begin
						// a bare thousand in the billions count still owes its billion word
						if (grp_q == nwt_pkg::GRP_BT) begin
							grp_d = nwt_pkg::GRP_B;
						end else begin
							state_d = nwt_pkg::ST_IDLE;
						end
					end else if (sts.rest_lt100) begin
						state_d = nwt_pkg::ST_AND;
						grp_d   = (grp_q == nwt_pkg::GRP_BT) ? nwt_pkg::GRP_B : nwt_pkg::GRP_U;
					end else begin
						state_d = nwt_pkg::ST_LEAD;
						grp_d   = next_grp;
					end
				end
			end
			nwt_pkg::ST_AND: begin
				if (sts.out_free) begin
					state_d = nwt_pkg::ST_LEAD;
				end
			end
			default: begin
				state_d = nwt_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd         = '0;
		cmd.grp     = grp_q;
		cmd.kind    = nwt_pkg::KIND_NUM;
		cmd.idx_sel = nwt_pkg::IDX_UNIT;
		in_ready    = state_q == nwt_pkg::ST_IDLE;
		case (state_q)
			nwt_pkg::ST_IDLE: begin
				cmd.load = in_valid;
			end
			nwt_pkg::ST_CONV: begin
				cmd.conv_step = !conv_done;
			end
			nwt_pkg::ST_LEAD: begin
				cmd.tok_load = sts.out_free;
				if (sts.h_nz) begin
					cmd.idx_sel = nwt_pkg::IDX_HUN;
				end else if (sts.t_ge2) begin
					cmd.idx_sel = nwt_pkg::IDX_TENS;
				end
			end
			nwt_pkg::ST_HWORD: begin
				cmd.tok_load = sts.out_free;
				cmd.kind     = nwt_pkg::KIND_HUNDRED;
			end
			nwt_pkg::ST_TENS: begin
				cmd.tok_load = sts.out_free;
				cmd.idx_sel  = nwt_pkg::IDX_TENS;
			end
			nwt_pkg::ST_UNIT: begin
				cmd.tok_load = sts.out_free;
			end
			nwt_pkg::ST_SCALE: begin
				cmd.tok_load = sts.out_free;
				case (grp_q)
					nwt_pkg::GRP_B: cmd.kind = nwt_pkg::KIND_BILLION;
					nwt_pkg::GRP_M: cmd.kind = nwt_pkg::KIND_MILLION;
					default:        cmd.kind = nwt_pkg::KIND_THOUSAND;
				endcase
			end
			nwt_pkg::ST_AND: begin
				cmd.tok_load = sts.out_free;
				cmd.kind     = nwt_pkg::KIND_AND;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
		cmd.last = cmd.tok_load && (state_d == nwt_pkg::ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nwt_pkg::ST_IDLE;
			grp_q   <= nwt_pkg::GRP_U;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			grp_q   <= grp_d;
			cnt_q   <= cnt_d;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tok_load |-> sts.out_free)
		else $error("token loaded while output register busy");

	a_and_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.tok_load && (cmd.kind == nwt_pkg::KIND_AND)) |-> !cmd.last)
		else $error("and marked as last word");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nwt_pkg::ST_CONV) |-> (cnt_q <= nwt_pkg::CNT_W'(nwt_pkg::NSTEP)))
		else $error("conversion counter overran");

	a_start_conv: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == nwt_pkg::ST_IDLE) && in_valid) |=>
		((state_q == nwt_pkg::ST_CONV) && (cnt_q == '0)))
		else $error("accepted word did not start conversion");

	a_and_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nwt_pkg::ST_AND) |-> ((grp_q == nwt_pkg::GRP_B) || (grp_q == nwt_pkg::GRP_U)))
		else $error("and followed by wrong group");

endmodule

`default_nettype wire

FILE: hw/rtl/number_to_word_tokens.sv
// Number to English word tokens: reads a whole number as a stream of word tokens.
//
// Input channel num carries one word: value (40 bits) and ordinal. Output channel tok
// carries one token per word: word_kind, word_index, ordinal_form and last_word, which
// marks the final token of a number. A number gives 1 to 20 tokens.
// After acceptance the value goes through a binary to BCD converter that takes 4 bits
// per cycle, then a decision step that picks the first digit group; from there the
// sequencer puts out one token per cycle while the receiver keeps up.
// num.ready is high only while the sequencer is idle; it rises again as soon as the
// last token enters the output register, so the next number is taken while that token
// still waits. When the receiver holds tok.ready low the output register keeps its
// token and the sequencer waits on it.
// Reset (arst_n low) empties the output register and returns the sequencer to idle.
`default_nettype none

module number_to_word_tokens (
	input logic         clk,
	input logic         arst_n,
	nwt_num_if.sink     num,
	nwt_tok_if.source   tok
);

	nwt_pkg::nwt_cmd_t cmd;
	nwt_pkg::nwt_sts_t sts;
	logic              ready;

	nwt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (num.valid),
		.in_ready (ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nwt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (num.value),
		.ordinal      (num.ordinal),
		.cmd          (cmd),
		.sts          (sts),
		.tok_valid    (tok.valid),
		.tok_ready    (tok.ready),
		.word_kind    (tok.word_kind),
		.word_index   (tok.word_index),
		.ordinal_form (tok.ordinal_form),
		.last_word    (tok.last_word)
	);

	assign num.ready = ready;

endmodule

`default_nettype wire
